// ----- rtl/core/arba_pkg.sv -----
// Shared types, codes and constants of the aligned region bitmap allocator.
`default_nettype none

package arba_pkg;

   localparam int WORD_BITS = 64;
   localparam int OFF_W = 6;
   localparam int POS_W = 10;
   localparam int BIU_W = 11;
   localparam int MAP_WORDS_DEFAULT = 16;
   localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;
   localparam logic [2:0] ORDER_MAX = 3'd6;

   typedef enum logic [1:0] {
      FUNC_FIND    = 2'd0,
      FUNC_ALLOC   = 2'd1,
      FUNC_RELEASE = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NOSPACE = 2'd2,
      STATUS_BUSY    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MODIFY,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_cmd_type;

   function automatic logic [WORD_BITS-1:0] region_mask(input logic [2:0] order);
      logic [WORD_BITS-1:0] m;
      begin
         unique case (order)
            3'd0: m = 64'h0000_0000_0000_0001;
            3'd1: m = 64'h0000_0000_0000_0003;
            3'd2: m = 64'h0000_0000_0000_000F;
            3'd3: m = 64'h0000_0000_0000_00FF;
            3'd4: m = 64'h0000_0000_0000_FFFF;
            3'd5: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
         endcase
         return m;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/arba_map_ram.sv -----
// Single-port-read, single-port-write bitmap word memory with registered read data.
`default_nettype none

module arba_map_ram #(
   parameter int DEPTH = arba_pkg::MAP_WORDS_DEFAULT,
   parameter int AW = 4
) (
   input  wire logic                           clock,
   input  wire arba_pkg::ram_cmd_type          cmd,
   input  wire logic [AW-1:0]                  rd_addr,
   input  wire logic [AW-1:0]                  wr_addr,
   input  wire logic [arba_pkg::WORD_BITS-1:0] wr_data,
   output logic      [arba_pkg::WORD_BITS-1:0] rd_data
);
   import arba_pkg::*;

   logic [WORD_BITS-1:0] mem_ff [0:DEPTH-1];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/arba_slot_find.sv -----
// Finds the lowest wholly free aligned slot of one bitmap word below the scan limit.
`default_nettype none

module arba_slot_find #(
   parameter int AW = 4
) (
   input  wire logic [arba_pkg::WORD_BITS-1:0] word,
   input  wire logic [2:0]                     order,
   input  wire logic [AW-1:0]                  word_idx,
   input  wire logic [arba_pkg::BIU_W-1:0]     bits_in_use,
   output logic                                hit,
   output logic      [arba_pkg::OFF_W-1:0]     offset
);
   import arba_pkg::*;

   localparam int HALF_BITS = WORD_BITS / 2;

   logic [WORD_BITS-1:0] lvl  [0:6];
   logic [WORD_BITS-1:0] cand [0:6];
   logic [WORD_BITS-1:0] sel;
   logic [WORD_BITS-1:0] lim_mask;
   logic [WORD_BITS-1:0] avail;
   logic [BIU_W-1:0]     wi;
   logic [BIU_W-1:0]     lw;

   always_comb begin
      lvl[0] = ~word;
      for (int k = 1; k < 7; k++) begin
         lvl[k] = '0;
         for (int j = 0; j < HALF_BITS; j++) begin
            lvl[k][j] = lvl[k-1][2*j] & lvl[k-1][2*j+1];
         end
      end
      for (int k = 0; k < 7; k++) begin
         cand[k] = '0;
         for (int b = 0; b < WORD_BITS; b++) begin
            if ((b & ((1 << k) - 1)) == 0) begin
               cand[k][b] = lvl[k][b >> k];
            end
         end
      end
   end

   always_comb begin
      case (order)
         3'd0: sel = cand[0];
         3'd1: sel = cand[1];
         3'd2: sel = cand[2];
         3'd3: sel = cand[3];
         3'd4: sel = cand[4];
         3'd5: sel = cand[5];
         default: sel = cand[6];
      endcase
   end

   always_comb begin
      wi = BIU_W'(word_idx);
      lw = BIU_W'(bits_in_use[BIU_W-1:OFF_W]);
      if (wi < lw) begin
         lim_mask = '1;
      end else if (wi == lw) begin
         lim_mask = (64'd1 << bits_in_use[OFF_W-1:0]) - 64'd1;
      end else begin
         lim_mask = '0;
      end
      avail = sel & lim_mask;
   end

   always_comb begin
      offset = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            offset = OFF_W'(b);
         end
      end
      hit = |avail;
   end

endmodule

`default_nettype wire

// ----- rtl/core/arba_ctrl.sv -----
// Request sequencer: clearing pass, word scan, read-modify-write and result register.
`default_nettype none

module arba_ctrl #(
   parameter int MAP_WORDS = arba_pkg::MAP_WORDS_DEFAULT,
   parameter int AW = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_func,
   input  wire logic [2:0]                     req_order,
   input  wire logic [arba_pkg::POS_W-1:0]     req_position,
   input  wire logic [arba_pkg::BIU_W-1:0]     bits_in_use,
   output arba_pkg::ram_cmd_type               ram_cmd,
   output logic      [AW-1:0]                  ram_rd_addr,
   output logic      [AW-1:0]                  ram_wr_addr,
   output logic      [arba_pkg::WORD_BITS-1:0] ram_wr_data,
   input  wire logic [arba_pkg::WORD_BITS-1:0] ram_rd_data,
   input  wire logic                           find_hit,
   input  wire logic [arba_pkg::OFF_W-1:0]     find_offset,
   output logic      [AW-1:0]                  find_word_idx,
   output logic      [2:0]                     find_order,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [1:0]                     rsp_status,
   output logic      [arba_pkg::POS_W-1:0]     rsp_found_position
);
   import arba_pkg::*;

   localparam logic [BIU_W-1:0] MAP_WORDS_W = BIU_W'(MAP_WORDS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

   state_type            state_ff, state_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [1:0]           op_ff, op_in;
   logic [2:0]           order_ff, order_in;
   logic [WORD_BITS-1:0] mask_ff, mask_in;
   logic [1:0]           pend_status_ff, pend_status_in;
   logic [POS_W-1:0]     pend_found_ff, pend_found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]     rsp_found_ff, rsp_found_in;

   logic                 word_exists;
   logic [AW-1:0]        req_addr;
   logic [BIU_W-1:0]     next_idx;
   logic [BIU_W-1:0]     lim_ceil;
   logic                 scan_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      order_ff       <= order_in;
      mask_ff        <= mask_in;
      pend_status_ff <= pend_status_in;
      pend_found_ff  <= pend_found_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
   end

   always_comb begin
      word_exists = BIU_W'(req_position[POS_W-1:OFF_W]) < MAP_WORDS_W;
      req_addr    = AW'(req_position[POS_W-1:OFF_W]);
      next_idx    = BIU_W'(addr_ff) + BIU_W'(1);
      lim_ceil    = BIU_W'(bits_in_use[BIU_W-1:OFF_W]) + BIU_W'(|bits_in_use[OFF_W-1:0]);
      scan_last   = (next_idx >= MAP_WORDS_W) || (next_idx >= lim_ceil);
   end

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      op_in          = op_ff;
      order_in       = order_ff;
      mask_in        = mask_ff;
      pend_status_in = pend_status_ff;
      pend_found_in  = pend_found_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      ram_cmd        = '0;
      ram_rd_addr    = addr_ff;
      ram_wr_addr    = addr_ff;
      ram_wr_data    = '0;
      req_stall      = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_cmd.wr_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in          = req_func;
               order_in       = req_order;
               mask_in        = region_mask(req_order) << req_position[OFF_W-1:0];
               pend_found_in  = '0;
               pend_status_in = STATUS_OK;
               unique case (req_func)
                  FUNC_FIND: begin
                     if (req_order > ORDER_MAX) begin
                        pend_status_in = STATUS_INVALID;
                        state_in       = ST_RESP;
                     end else begin
                        ram_cmd.rd_en = 1'b1;
                        ram_rd_addr   = '0;
                        addr_in       = '0;
                        state_in      = ST_SCAN;
                     end
                  end
                  FUNC_ALLOC: begin
                     if (req_order > ORDER_MAX) begin
                        pend_status_in = STATUS_INVALID;
                        state_in       = ST_RESP;
                     end else if (!word_exists) begin
                        pend_status_in = STATUS_BUSY;
                        state_in       = ST_RESP;
                     end else begin
                        ram_cmd.rd_en = 1'b1;
                        ram_rd_addr   = req_addr;
                        addr_in       = req_addr;
                        state_in      = ST_MODIFY;
                     end
                  end
                  FUNC_RELEASE: begin
                     if (req_order > ORDER_MAX || !word_exists) begin
                        state_in = ST_RESP;
                     end else begin
                        ram_cmd.rd_en = 1'b1;
                        ram_rd_addr   = req_addr;
                        addr_in       = req_addr;
                        state_in      = ST_MODIFY;
                     end
                  end
                  default: begin
                     pend_status_in = STATUS_INVALID;
                     state_in       = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (find_hit) begin
               ram_cmd.wr_en  = 1'b1;
               ram_wr_data    = ram_rd_data | (region_mask(order_ff) << find_offset);
               pend_status_in = STATUS_OK;
               pend_found_in  = POS_W'({addr_ff, find_offset});
               state_in       = ST_RESP;
            end else if (scan_last) begin
               pend_status_in = STATUS_NOSPACE;
               state_in       = ST_RESP;
            end else begin
               ram_cmd.rd_en = 1'b1;
               ram_rd_addr   = addr_ff + AW'(1);
               addr_in       = addr_ff + AW'(1);
            end
         end
         ST_MODIFY: begin
            if (op_ff == FUNC_ALLOC) begin
               if ((ram_rd_data & mask_ff) != '0) begin
                  pend_status_in = STATUS_BUSY;
               end else begin
                  ram_cmd.wr_en = 1'b1;
                  ram_wr_data   = ram_rd_data | mask_ff;
               end
            end else begin
               ram_cmd.wr_en = 1'b1;
               ram_wr_data   = ram_rd_data & ~mask_ff;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_found_in  = pend_found_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign find_word_idx      = addr_ff;
   assign find_order         = order_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;

endmodule

`default_nettype wire

// ----- rtl/core/aligned_region_bitmap_allocator_core.sv -----
// Top level of the aligned power-of-two region allocator over a word bitmap.
//
// Requests arrive on the req_ channel (func, order, position) and each gives
// exactly one beat on the rsp_ channel (status, found_position). Both channels
// accept a beat at a rising clock edge with valid high and stall low.
// The bits_in_use register is written through csr_write_enable and
// csr_write_data and limits where a find may start a region.
// One request is worked on at a time. A find reads one bitmap word per cycle
// from word 0 until it finds a free slot or reaches the last word of the map
// or of the scan limit. Allocate and release read the addressed word, write
// it back unless an allocate finds the region busy, and load the response;
// rejected requests go straight to the response load.
// After reset the bitmap memory is swept to all-free, one word per cycle,
// while req_stall stays high; csr writes are taken.
// The response sits in an output register; a stalled beat holds its payload,
// and a finished request waits in the response state until the receiver takes the beat.
`default_nettype none

module aligned_region_bitmap_allocator_core #(
   parameter int MAP_WORDS = arba_pkg::MAP_WORDS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_func,
   input  wire logic [2:0]                 req_order,
   input  wire logic [arba_pkg::POS_W-1:0] req_position,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [1:0]                 rsp_status,
   output logic      [arba_pkg::POS_W-1:0] rsp_found_position,
   input  wire logic                       csr_write_enable,
   input  wire logic [arba_pkg::BIU_W-1:0] csr_write_data
);
   import arba_pkg::*;

   localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   logic [BIU_W-1:0]     bits_in_use_ff;
   ram_cmd_type          ram_cmd;
   logic [AW-1:0]        ram_rd_addr;
   logic [AW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 find_hit;
   logic [OFF_W-1:0]     find_offset;
   logic [AW-1:0]        find_word_idx;
   logic [2:0]           find_order;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_in_use_ff <= BIU_RESET;
      end else if (csr_write_enable) begin
         bits_in_use_ff <= csr_write_data;
      end
   end

   arba_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_addr (ram_rd_addr),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   arba_slot_find #(
      .AW (AW)
   ) u_slot_find (
      .word        (ram_rd_data),
      .order       (find_order),
      .word_idx    (find_word_idx),
      .bits_in_use (bits_in_use_ff),
      .hit         (find_hit),
      .offset      (find_offset)
   );

   arba_ctrl #(
      .MAP_WORDS (MAP_WORDS),
      .AW        (AW)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_order          (req_order),
      .req_position       (req_position),
      .bits_in_use        (bits_in_use_ff),
      .ram_cmd            (ram_cmd),
      .ram_rd_addr        (ram_rd_addr),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_data        (ram_rd_data),
      .find_hit           (find_hit),
      .find_offset        (find_offset),
      .find_word_idx      (find_word_idx),
      .find_order         (find_order),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the aligned region bitmap allocator core.
`default_nettype none

module tb_top;
   import arba_pkg::*;

   localparam int MAP_WORDS = 16;
   localparam int MAP_BITS = MAP_WORDS * WORD_BITS;
   localparam int LIMIT_CYCLES = 500000;

   typedef struct {
      status_type        status;
      logic [POS_W-1:0]  found;
   } alloc_result_type;

   typedef struct {
      logic [2:0]        order;
      logic [POS_W-1:0]  pos;
   } held_region_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_func = '0;
   logic [2:0]           req_order = '0;
   logic [POS_W-1:0]     req_position = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [POS_W-1:0]     rsp_found_position;
   logic                 csr_write_enable = 1'b0;
   logic [BIU_W-1:0]     csr_write_data = '0;

   logic [WORD_BITS-1:0] bitmap_model [MAP_WORDS];
   logic [BIU_W-1:0]     biu_model = BIU_RESET;
   alloc_result_type     expected_beats [$];
   held_region_type      held_regions [$];
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   mismatch_count = 0;
   int                   sent_count = 0;
   int                   checked_count = 0;
   int                   status_seen [4] = '{0, 0, 0, 0};
   int                   cycle_count = 0;

   aligned_region_bitmap_allocator_core #(
      .MAP_WORDS(MAP_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_order(req_order),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found_position(rsp_found_position),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d beats outstanding.", cycle_count,
                  expected_beats.size());
         $display("aligned_region_bitmap_allocator_core test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      begin
         mismatch_count++;
         $display("Mismatch on beat %0d: %s is %0d, expected %0d.", checked_count, what,
                  got, want);
      end
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat status", rsp_status, -1);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_found_position !== want.found)
               report_mismatch("found_position", rsp_found_position, want.found);
            status_seen[want.status]++;
         end
         checked_count++;
      end
   end

   function automatic alloc_result_type predict_request(input func_type f,
                                                        input logic [2:0] order,
                                                        input logic [POS_W-1:0] pos);
      alloc_result_type r;
      logic [WORD_BITS-1:0] span_mask;
      logic [WORD_BITS-1:0] slot_mask;
      int span;
      int limit;
      int w;
      int i;
      bit hit;
      begin
         r.status = STATUS_OK;
         r.found = '0;
         span = 1 << order;
         span_mask = (order >= 3'd6) ? '1 : ((64'd1 << span) - 64'd1);
         w = pos / WORD_BITS;
         slot_mask = span_mask << pos[OFF_W-1:0];
         hit = 1'b0;
         case (f)
            FUNC_FIND: begin
               if (order > ORDER_MAX) begin
                  r.status = STATUS_INVALID;
               end else begin
                  limit = (biu_model > MAP_BITS) ? MAP_BITS : int'(biu_model);
                  r.status = STATUS_NOSPACE;
                  for (i = 0; i < limit && !hit; i += span) begin
                     slot_mask = span_mask << (i % WORD_BITS);
                     if ((bitmap_model[i / WORD_BITS] & slot_mask) == '0) begin
                        bitmap_model[i / WORD_BITS] |= slot_mask;
                        r.status = STATUS_OK;
                        r.found = i[POS_W-1:0];
                        hit = 1'b1;
                     end
                  end
               end
            end
            FUNC_ALLOC: begin
               if (order > ORDER_MAX)
                  r.status = STATUS_INVALID;
               else if (w >= MAP_WORDS || (bitmap_model[w] & slot_mask) != '0)
                  r.status = STATUS_BUSY;
               else
                  bitmap_model[w] |= slot_mask;
            end
            FUNC_RELEASE: begin
               if (order <= ORDER_MAX && w < MAP_WORDS)
                  bitmap_model[w] &= ~slot_mask;
            end
            default: r.status = STATUS_INVALID;
         endcase
         return r;
      end
   endfunction

   task automatic send_request(input func_type f, input logic [2:0] order,
                               input logic [POS_W-1:0] pos);
      alloc_result_type r;
      held_region_type h;
      begin
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_func <= f;
         req_order <= order;
         req_position <= pos;
         forever begin
            @(posedge clock);
            if (!req_stall) break;
         end
         r = predict_request(f, order, pos);
         expected_beats.push_back(r);
         sent_count++;
         if (r.status == STATUS_OK && (f == FUNC_FIND || f == FUNC_ALLOC)) begin
            h.order = order;
            h.pos = (f == FUNC_FIND) ? r.found : pos;
            held_regions.push_back(h);
         end
      end
   endtask

   task automatic settle();
      begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (expected_beats.size() != 0) @(posedge clock);
         repeat (MAP_WORDS + 4) @(posedge clock);
      end
   endtask

   task automatic write_bits_in_use(input logic [BIU_W-1:0] value);
      begin
         settle();
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data <= value;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         biu_model = value;
      end
   endtask

   task automatic clear_whole_map();
      int k;
      begin
         for (k = 0; k < MAP_WORDS; k++)
            send_request(FUNC_RELEASE, 3'd6, POS_W'(k * WORD_BITS));
         held_regions.delete();
      end
   endtask

   task automatic test_directed();
      int k;
      begin
         for (k = 0; k <= 6; k++)
            send_request(FUNC_FIND, 3'(k), '0);
         send_request(FUNC_FIND, 3'd7, 10'h3FF);
         send_request(FUNC_ALLOC, 3'd7, 10'h000);
         send_request(FUNC_RELEASE, 3'd7, 10'h000);
         send_request(FUNC_UNUSED, 3'd0, 10'h155);
         send_request(FUNC_UNUSED, 3'd7, 10'h2AA);
         send_request(FUNC_ALLOC, 3'd0, 10'h000);
         send_request(FUNC_ALLOC, 3'd6, 10'h3FC);
         send_request(FUNC_ALLOC, 3'd0, 10'h3FF);
         send_request(FUNC_ALLOC, 3'd3, 10'h3FA);
         send_request(FUNC_RELEASE, 3'd6, 10'h3FC);
         send_request(FUNC_ALLOC, 3'd0, 10'h3FF);
         send_request(FUNC_RELEASE, 3'd6, 10'h000);
         send_request(FUNC_ALLOC, 3'd6, 10'h000);
         send_request(FUNC_ALLOC, 3'd5, 10'h020);
         send_request(FUNC_RELEASE, 3'd5, 10'h030);
         send_request(FUNC_FIND, 3'd4, '0);
      end
   endtask

   task automatic test_scan_limit();
      logic [BIU_W-1:0] limits [6];
      int k;
      begin
         limits = '{11'd0, 11'd1, 11'h7FF, 11'd64, 11'd1000, 11'd1024};
         foreach (limits[j]) begin
            write_bits_in_use(limits[j]);
            clear_whole_map();
            send_request(FUNC_FIND, 3'd6, '0);
            send_request(FUNC_FIND, 3'd0, '0);
            send_request(FUNC_FIND, 3'd3, '0);
         end
         write_bits_in_use(11'd128);
         for (k = 0; k < 3; k++)
            send_request(FUNC_FIND, 3'd6, '0);
      end
   endtask

   task automatic random_request();
      int pick;
      int idx;
      int span;
      logic [2:0] order;
      logic [POS_W-1:0] pos;
      held_region_type h;
      begin
         pick = $urandom_range(99);
         order = 3'($urandom_range(6));
         span = 1 << order;
         pos = POS_W'($urandom_range(MAP_BITS - 1));
         if (pick < 30) begin
            send_request(FUNC_FIND, order, pos);
         end else if (pick < 50) begin
            if ($urandom_range(4) != 0)
               pos = pos & ~POS_W'(span - 1);
            send_request(FUNC_ALLOC, order, pos);
         end else if (pick < 80 && held_regions.size() != 0) begin
            idx = $urandom_range(held_regions.size() - 1);
            h = held_regions[idx];
            held_regions.delete(idx);
            send_request(FUNC_RELEASE, h.order, h.pos);
         end else if (pick < 88) begin
            send_request(FUNC_RELEASE, order, pos);
         end else if ($urandom_range(1) == 0) begin
            send_request(FUNC_UNUSED, 3'($urandom_range(7)), pos);
         end else begin
            send_request(func_type'($urandom_range(2)), 3'd7, pos);
         end
      end
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      int n;
      begin
         send_idle_pct = idle_pct;
         rsp_stall_pct = stall_pct;
         for (n = 0; n < count; n++) begin
            if (n == count / 2) settle();
            random_request();
         end
      end
   endtask

   initial begin
      foreach (bitmap_model[k]) bitmap_model[k] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_scan_limit();
      write_bits_in_use(BIU_RESET);
      test_random_traffic(120, 0, 0);
      write_bits_in_use(11'($urandom_range(1, 1024)));
      test_random_traffic(120, 58, 0);
      write_bits_in_use(11'h7FF);
      test_random_traffic(120, 0, 58);
      write_bits_in_use(11'($urandom_range(700, 1024)));
      test_random_traffic(120, 18, 18);
      settle();
      $display("Sent %0d requests and checked %0d beats in %0d cycles.", sent_count,
               checked_count, cycle_count);
      $display("Statuses seen: ok %0d, invalid %0d, no space %0d, busy %0d.",
               status_seen[STATUS_OK], status_seen[STATUS_INVALID],
               status_seen[STATUS_NOSPACE], status_seen[STATUS_BUSY]);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("aligned_region_bitmap_allocator_core test passed");
      end else begin
         $display("aligned_region_bitmap_allocator_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/arba_pkg.sv
rtl/core/arba_map_ram.sv
rtl/core/arba_slot_find.sv
rtl/core/arba_ctrl.sv
rtl/core/aligned_region_bitmap_allocator_core.sv
tb/sv/tb_top.sv
